/* hdl/sbrf_pkg.sv */
`timescale 1ns / 1ps

package sbrf_pkg;

  // Fixed point layout
  localparam int unsigned FracBits = 28;
  localparam int unsigned XW       = 31;
  localparam int unsigned AccW     = 64;
  localparam int unsigned TolW     = 29;
  localparam int unsigned HalfW    = 32;
  localparam int unsigned PpW      = HalfW + XW;
  localparam int unsigned ProdW    = 2 * HalfW + XW;
  localparam int unsigned RW       = 62;

  // Segments and coefficients
  localparam int unsigned NumSeg  = 5;
  localparam int unsigned NumCoef = 4;

  localparam logic [1:0] CoefA = 2'd0;
  localparam logic [1:0] CoefC = 2'd2;
  localparam logic [1:0] CoefD = 2'd3;

  // Configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam logic        RegTolerance = 1'b0;
  localparam logic [TolW-1:0] TolMin = TolW'(2);

  // Q.36 conversion of values given in units of 1e-5, rounded half away from zero
  localparam logic [63:0] One36 = 64'd1 << 36;
  localparam logic [63:0] QDen  = 64'd100000;
  localparam logic [63:0] QHalf = 64'd50000;

  localparam logic [AccW-1:0] SegCoef [NumSeg][NumCoef] = '{
    '{64'd0 - (64'd100000 * One36 + QHalf) / QDen,
      (64'd180861 * One36 + QHalf) / QDen,
      64'd0,
      (64'd19139 * One36 + QHalf) / QDen},
    '{(64'd114833 * One36 + QHalf) / QDen,
      64'd0 - (64'd463636 * One36 + QHalf) / QDen,
      (64'd644498 * One36 + QHalf) / QDen,
      64'd0 - (64'd195694 * One36 + QHalf) / QDen},
    '{64'd0 - (64'd5159809 * One36 + QHalf) / QDen,
      (64'd7448325 * One36 + QHalf) / QDen,
      64'd0 - (64'd3311483 * One36 + QHalf) / QDen,
      (64'd463636 * One36 + QHalf) / QDen},
    '{(64'd22447368 * One36 + QHalf) / QDen,
      64'd0 - (64'd20158852 * One36 + QHalf) / QDen,
      (64'd5890909 * One36 + QHalf) / QDen,
      64'd0 - (64'd558852 * One36 + QHalf) / QDen},
    '{64'd0 - (64'd30712440 * One36 + QHalf) / QDen,
      (64'd19711005 * One36 + QHalf) / QDen,
      64'd0 - (64'd4076555 * One36 + QHalf) / QDen,
      (64'd271770 * One36 + QHalf) / QDen}
  };

  // Evaluation request and response between sequencer and Horner unit
  typedef struct packed {
    logic          start;
    logic [XW-1:0] x;
  } horner_req_t;

  typedef struct packed {
    logic            done;
    logic [AccW-1:0] value;
  } horner_rsp_t;

endpackage

/* hdl/sbrf_if.sv */
`timescale 1ns / 1ps

// Interval request channel
interface sbrf_in_if;
  logic                    valid;
  logic                    ready;
  logic [sbrf_pkg::XW-1:0] lower_bound;
  logic [sbrf_pkg::XW-1:0] upper_bound;

  modport source (output valid, output lower_bound, output upper_bound, input ready);
  modport sink   (input valid, input lower_bound, input upper_bound, output ready);
endinterface

// Result channel
interface sbrf_out_if;
  logic                    valid;
  logic                    ready;
  logic [sbrf_pkg::XW-1:0] root;
  logic                    status;
  logic                    exact_zero;

  modport source (output valid, output root, output status, output exact_zero, input ready);
  modport sink   (input valid, input root, input status, input exact_zero, output ready);
endinterface

/* hdl/sbrf_horner.sv */
`timescale 1ns / 1ps

// Spline evaluation by Horner's rule on one shared 32x31 multiplier.
// Each step: magnitude, low partial product, high partial product, add.
module sbrf_horner (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sbrf_pkg::horner_req_t req_i,
  output sbrf_pkg::horner_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    H_IDLE,
    H_ABS,
    H_MUL_LO,
    H_MUL_HI,
    H_ADD
  } horner_state_e;

  horner_state_e                 state_q;
  logic [sbrf_pkg::XW-1:0]       x_q;
  logic [2:0]                    seg_q;
  logic [1:0]                    k_q;
  logic [sbrf_pkg::AccW-1:0]     acc_q;
  logic [sbrf_pkg::AccW-1:0]     mag_q;
  logic                          neg_q;
  logic [sbrf_pkg::ProdW-1:0]    prod_q;
  logic                          done_q;

  logic [2:0]                    seg_sel;
  logic [sbrf_pkg::HalfW-1:0]    mul_a;
  logic [sbrf_pkg::PpW-1:0]      pp;
  logic [sbrf_pkg::AccW-1:0]     r_ext;
  logic [sbrf_pkg::AccW-1:0]     coef;
  logic [sbrf_pkg::AccW-1:0]     acc_sum;

  // Segment from x: boundaries at 1, 2, 3 and 4, inclusive on the upper side
  always_comb begin
    if (req_i.x <= sbrf_pkg::XW'(1) << sbrf_pkg::FracBits) begin
      seg_sel = 3'd0;
    end else if (req_i.x <= sbrf_pkg::XW'(2) << sbrf_pkg::FracBits) begin
      seg_sel = 3'd1;
    end else if (req_i.x <= sbrf_pkg::XW'(3) << sbrf_pkg::FracBits) begin
      seg_sel = 3'd2;
    end else if (req_i.x <= sbrf_pkg::XW'(4) << sbrf_pkg::FracBits) begin
      seg_sel = 3'd3;
    end else begin
      seg_sel = 3'd4;
    end
  end

  // Shared multiplier, one half of the magnitude per cycle
  assign mul_a = (state_q == H_MUL_LO) ? mag_q[sbrf_pkg::HalfW-1:0]
                                       : mag_q[sbrf_pkg::AccW-1:sbrf_pkg::HalfW];
  assign pp    = sbrf_pkg::PpW'(mul_a) * sbrf_pkg::PpW'(x_q);

  // Truncated magnitude, sign put back by add or subtract
  assign r_ext   = sbrf_pkg::AccW'(prod_q[sbrf_pkg::FracBits + sbrf_pkg::RW - 1:
                                          sbrf_pkg::FracBits]);
  assign coef    = sbrf_pkg::SegCoef[seg_q][k_q];
  assign acc_sum = neg_q ? coef - r_ext : coef + r_ext;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      x_q     <= '0;
      seg_q   <= '0;
      k_q     <= '0;
      acc_q   <= '0;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      prod_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        H_IDLE: begin
          if (req_i.start) begin
            x_q     <= req_i.x;
            seg_q   <= seg_sel;
            acc_q   <= sbrf_pkg::SegCoef[seg_sel][sbrf_pkg::CoefD];
            k_q     <= sbrf_pkg::CoefC;
            state_q <= H_ABS;
          end
        end
        H_ABS: begin
          neg_q   <= acc_q[sbrf_pkg::AccW-1];
          mag_q   <= acc_q[sbrf_pkg::AccW-1] ? '0 - acc_q : acc_q;
          state_q <= H_MUL_LO;
        end
        H_MUL_LO: begin
          prod_q  <= sbrf_pkg::ProdW'(pp);
          state_q <= H_MUL_HI;
        end
        H_MUL_HI: begin
          prod_q  <= prod_q + {pp, sbrf_pkg::HalfW'(0)};
          state_q <= H_ADD;
        end
        H_ADD: begin
          acc_q <= acc_sum;
          if (k_q == sbrf_pkg::CoefA) begin
            done_q  <= 1'b1;
            state_q <= H_IDLE;
          end else begin
            k_q     <= k_q - 2'd1;
            state_q <= H_ABS;
          end
        end
        default: state_q <= H_IDLE;
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = acc_q;

endmodule

/* hdl/spline_bisection_root_finder.sv */
`timescale 1ns / 1ps
// Each request evaluates the spline at both ends; when they show no sign change the result
// is ready, else bisection steps follow, each evaluating the spline at the new midpoint.
// Requests are taken only in the idle state; the shared Horner unit computes every value.
// A new request is taken while the previous result waits in the output register.
// Reset (rst_ni, asynchronous, active low) clears control state, tolerance reads 1.

module spline_bisection_root_finder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbrf_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  sbrf_in_if.sink                       in_i,
  sbrf_out_if.source                    out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL_LO,
    S_EVAL_HI,
    S_BISECT,
    S_EVAL_MID,
    S_FINISH
  } sbrf_state_e;

  sbrf_state_e               state_q;
  logic [sbrf_pkg::XW-1:0]   low_q;
  logic [sbrf_pkg::XW-1:0]   high_q;
  logic [sbrf_pkg::XW-1:0]   mid_q;
  logic                      sign_low_q;
  logic                      fl_neg_q;
  logic                      fl_zero_q;
  logic                      status_q;
  logic                      exact_q;
  logic [sbrf_pkg::TolW-1:0] tol_q;
  sbrf_pkg::horner_req_t     hreq_q;
  sbrf_pkg::horner_rsp_t     hrsp;
  logic                      out_valid_q;
  logic [sbrf_pkg::XW-1:0]   out_root_q;
  logic                      out_status_q;
  logic                      out_exact_q;

  logic                      cfg_write;
  logic [sbrf_pkg::TolW-1:0] tol_eff;
  logic [sbrf_pkg::XW-1:0]   width;
  logic                      keep_going;
  logic [sbrf_pkg::XW:0]     mid_sum;
  logic [sbrf_pkg::XW-1:0]   mid_next;
  logic                      v_neg;
  logic                      v_zero;

  // Configuration register
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == sbrf_pkg::RegTolerance) ? 32'(tol_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= sbrf_pkg::TolW'(1);
    end else if (cfg_write && paddr[2] == sbrf_pkg::RegTolerance) begin
      tol_q <= pwdata[sbrf_pkg::TolW-1:0];
    end
  end

  // Horner unit
  sbrf_horner u_horner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hreq_q),
    .rsp_o  (hrsp)
  );

  // Bisection step terms
  assign tol_eff    = (tol_q < sbrf_pkg::TolMin) ? sbrf_pkg::TolMin : tol_q;
  assign width      = high_q - low_q;
  assign keep_going = (high_q > low_q) && (width >= sbrf_pkg::XW'(tol_eff));
  assign mid_sum    = {1'b0, high_q} + {1'b0, low_q};
  assign mid_next   = mid_sum[sbrf_pkg::XW:1];
  assign v_neg      = hrsp.value[sbrf_pkg::AccW-1];
  assign v_zero     = (hrsp.value == '0);

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      low_q        <= '0;
      high_q       <= '0;
      mid_q        <= '0;
      sign_low_q   <= 1'b0;
      fl_neg_q     <= 1'b0;
      fl_zero_q    <= 1'b0;
      status_q     <= 1'b0;
      exact_q      <= 1'b0;
      hreq_q       <= '0;
      out_valid_q  <= 1'b0;
      out_root_q   <= '0;
      out_status_q <= 1'b0;
      out_exact_q  <= 1'b0;
    end else begin
      hreq_q.start <= 1'b0;
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            low_q        <= in_i.lower_bound;
            high_q       <= in_i.upper_bound;
            mid_q        <= in_i.lower_bound;
            hreq_q.start <= 1'b1;
            hreq_q.x     <= in_i.lower_bound;
            state_q      <= S_EVAL_LO;
          end
        end
        S_EVAL_LO: begin
          if (hrsp.done) begin
            fl_neg_q     <= v_neg;
            fl_zero_q    <= v_zero;
            hreq_q.start <= 1'b1;
            hreq_q.x     <= high_q;
            state_q      <= S_EVAL_HI;
          end
        end
        S_EVAL_HI: begin
          if (hrsp.done) begin
            if (fl_zero_q || v_zero || (fl_neg_q == v_neg)) begin
              status_q <= 1'b1;
              exact_q  <= 1'b0;
              state_q  <= S_FINISH;
            end else begin
              sign_low_q <= fl_neg_q;
              state_q    <= S_BISECT;
            end
          end
        end
        S_BISECT: begin
          if (keep_going) begin
            mid_q        <= mid_next;
            hreq_q.start <= 1'b1;
            hreq_q.x     <= mid_next;
            state_q      <= S_EVAL_MID;
          end else begin
            status_q <= 1'b0;
            exact_q  <= 1'b0;
            state_q  <= S_FINISH;
          end
        end
        S_EVAL_MID: begin
          if (hrsp.done) begin
            if (v_zero) begin
              status_q <= 1'b0;
              exact_q  <= 1'b1;
              state_q  <= S_FINISH;
            end else begin
              if (v_neg != sign_low_q) begin
                high_q <= mid_q;
              end else begin
                low_q      <= mid_q;
                sign_low_q <= v_neg;
              end
              state_q <= S_BISECT;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_root_q   <= mid_q;
            out_status_q <= status_q;
            out_exact_q  <= exact_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.root       = out_root_q;
  assign out_o.status     = out_status_q;
  assign out_o.exact_zero = out_exact_q;

`ifndef SYNTHESIS
  // Midpoint under evaluation lies strictly inside the interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL_MID |-> (low_q < mid_q) && (mid_q < high_q))
    else $error("midpoint outside interval");

  // Horner results arrive only while a value is awaited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hrsp.done |-> (state_q == S_EVAL_LO || state_q == S_EVAL_HI || state_q == S_EVAL_MID))
    else $error("unexpected Horner result");

  // No sign change never reports an exact zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.status && out_o.exact_zero))
    else $error("inconsistent result flags");

  // Each bisection step narrows the interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BISECT && $past(state_q) == S_EVAL_MID)
      |-> (width < $past(width)))
    else $error("interval did not shrink");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ApbAddrW = sbrf_pkg::ApbAddrW;
  localparam logic RegTolerance = sbrf_pkg::RegTolerance;
  localparam int unsigned XW = sbrf_pkg::XW;
  localparam int unsigned FracBits = sbrf_pkg::FracBits;
  localparam int unsigned TolW = sbrf_pkg::TolW;
  localparam logic [TolW-1:0] TolMin = sbrf_pkg::TolMin;
  localparam int unsigned NumSeg = sbrf_pkg::NumSeg;

  localparam int unsigned CycleLimit = 10_000_000;
  localparam int unsigned DrainCycles = 600;
  localparam int unsigned MaxReports = 10;
  localparam logic [ApbAddrW-1:0] TolAddr = ApbAddrW'(4 * RegTolerance);
  localparam logic [XW-1:0] XOne = XW'(1) << FracBits;
  localparam logic [XW-1:0] XFive = XW'(5) << FracBits;
  localparam logic [XW-1:0] XAllOnes = '1;
  localparam logic [TolW-1:0] TolTop = TolW'(1) << FracBits;
  localparam longint Q36One = longint'(1) << 36;

  // Expected outcome of one interval request
  typedef struct packed {
    logic [XW-1:0] root;
    logic          status;
    logic          exact_zero;
  } root_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [ApbAddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  sbrf_in_if  in_if ();
  sbrf_out_if out_if ();

  spline_bisection_root_finder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  root_result_t expected_roots[$];
  logic [TolW-1:0] tol_setting = TolW'(1);
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned intervals_sent = 0;
  int unsigned results_checked = 0;
  int unsigned no_sign_seen = 0;
  int unsigned exact_zero_seen = 0;
  int unsigned tol_settings = 0;
  int unsigned cycle_count = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timed out after %0d cycles, %0d results outstanding", cycle_count,
               expected_roots.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic void flag_mismatch(string what, longint unsigned want,
                                        longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= MaxReports)
      $display("[%0t] mismatch in %s: expected %h, got %h", $realtime, what, want, got);
  endfunction

  // Spline coefficients a, b, c, d per segment, in units of 1e-5
  function automatic longint coef_units(int unsigned seg, int unsigned k);
    logic [3:0][63:0] row;
    case (seg)
      0: row = {64'sd19139, 64'sd0, 64'sd180861, -64'sd100000};
      1: row = {-64'sd195694, 64'sd644498, -64'sd463636, 64'sd114833};
      2: row = {64'sd463636, -64'sd3311483, 64'sd7448325, -64'sd5159809};
      3: row = {-64'sd558852, 64'sd5890909, -64'sd20158852, 64'sd22447368};
      default: row = {64'sd271770, -64'sd4076555, 64'sd19711005, -64'sd30712440};
    endcase
    return longint'(row[k]);
  endfunction

  // Q.36, rounded to nearest with ties away from zero
  function automatic longint to_q36(longint units);
    if (units >= 0) return (units * Q36One + 50000) / 100000;
    return -(((-units) * Q36One + 50000) / 100000);
  endfunction

  // acc * x with the magnitude truncated to Q.36, sign put back
  function automatic logic signed [63:0] scale_by_x(logic signed [63:0] acc,
                                                    logic [XW-1:0] x);
    logic [63:0] mag;
    logic [95:0] prod;
    logic [63:0] shifted;
    mag = acc[63] ? (64'd0 - acc) : acc;
    prod = {32'd0, mag} * {65'd0, x};
    shifted = {2'b00, prod[FracBits +: 62]};
    return acc[63] ? -$signed(shifted) : $signed(shifted);
  endfunction

  function automatic logic signed [63:0] spline_at(logic [XW-1:0] x);
    int unsigned seg;
    logic signed [63:0] acc;
    seg = 0;
    for (int k = 1; k < NumSeg; k++)
      if (x > (XW'(k) << FracBits)) seg = k;
    acc = to_q36(coef_units(seg, 3));
    for (int k = 2; k >= 0; k--)
      acc = scale_by_x(acc, x) + to_q36(coef_units(seg, k));
    return acc;
  endfunction

  // Bisection as the block should perform it for one request
  function automatic root_result_t predict_root(logic [XW-1:0] lo, logic [XW-1:0] hi);
    logic [TolW-1:0] tol;
    logic [XW-1:0] left, right, mid;
    logic [XW:0] sum;
    logic signed [63:0] f_lo, f_hi, f_mid;
    logic neg_left, hit_zero;
    root_result_t r;
    tol = (tol_setting < TolMin) ? TolMin : tol_setting;
    f_lo = spline_at(lo);
    f_hi = spline_at(hi);
    r.root = lo;
    r.status = 1'b1;
    r.exact_zero = 1'b0;
    if (f_lo == 0 || f_hi == 0 || f_lo[63] == f_hi[63]) return r;
    r.status = 1'b0;
    left = lo;
    right = hi;
    mid = lo;
    neg_left = f_lo[63];
    hit_zero = 1'b0;
    while (!hit_zero && right > left && right - left >= tol) begin
      sum = {1'b0, left} + {1'b0, right};
      mid = sum[XW:1];
      f_mid = spline_at(mid);
      if (f_mid == 0) begin
        hit_zero = 1'b1;
      end else if (f_mid[63] != neg_left) begin
        right = mid;
      end else begin
        left = mid;
        neg_left = f_mid[63];
      end
    end
    r.root = mid;
    r.exact_zero = hit_zero;
    return r;
  endfunction

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk_i) begin
    root_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_roots.size() == 0) begin
        flag_mismatch("unexpected result root", 0, out_if.root);
      end else begin
        want = expected_roots.pop_front();
        results_checked++;
        if (want.status) no_sign_seen++;
        if (want.exact_zero) exact_zero_seen++;
        if (out_if.root !== want.root) flag_mismatch("root", want.root, out_if.root);
        if (out_if.status !== want.status) flag_mismatch("status", want.status, out_if.status);
        if (out_if.exact_zero !== want.exact_zero)
          flag_mismatch("exact_zero", want.exact_zero, out_if.exact_zero);
      end
    end
  end

  // Receiver stalls
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One request, with a random gap first; valid stays high for a back-to-back request
  task automatic send_interval(logic [XW-1:0] lo, logic [XW-1:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.lower_bound = lo;
    in_if.upper_bound = hi;
    do @(posedge clk_i); while (!in_if.ready);
    expected_roots.push_back(predict_root(lo, hi));
    intervals_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    in_if.valid = 1'b0;
    while (expected_roots.size() != 0) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic write, input logic [ApbAddrW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = write;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Only written with the block idle; read back to confirm
  task automatic set_tolerance(logic [TolW-1:0] value);
    logic [31:0] readback;
    wait_for_results();
    apb_access(1'b1, TolAddr, 32'(value), readback);
    tol_setting = value;
    apb_access(1'b0, TolAddr, '0, readback);
    if (readback !== 32'(value)) flag_mismatch("tolerance readback", value, readback);
    tol_settings++;
  endtask

  task automatic test_register_reset();
    logic [31:0] readback;
    apb_access(1'b0, TolAddr, '0, readback);
    if (readback !== 32'd1) flag_mismatch("tolerance after reset", 1, readback);
  endtask

  task automatic test_directed_intervals();
    send_idle_pct = 13;
    recv_idle_pct = 49;
    set_tolerance(TolW'(1));
    // one bracket per root
    send_interval('0, XOne);
    send_interval(XW'(2) << FracBits, XW'(3) << FracBits);
    send_interval(XW'(3) << FracBits, XW'(4) << FracBits);
    send_interval(XW'(4) << FracBits, XFive);
    // ends of equal sign
    send_interval('0, XFive);
    send_interval(XOne, XW'(2) << FracBits);
    send_interval('0, XW'(1));
    // empty and reversed intervals
    send_interval(XOne, XOne);
    send_interval('0, '0);
    send_interval(XOne, '0);
    send_interval(XFive, XW'(4) << FracBits);
    // beyond five, last segment carries on
    send_interval(XAllOnes, XAllOnes);
    send_interval(XW'(4) << FracBits, XAllOnes);
    send_interval('0, XAllOnes);
    send_interval((XW'(2) << FracBits) + 1, XAllOnes);
    send_interval(XOne - 1, XOne + 1);
    send_interval(XFive + 1, XAllOnes - 1);
  endtask

  // Tolerance of zero, two, top of range and all ones over the four brackets
  task automatic test_tolerance_extremes();
    int unsigned start;
    for (int t = 0; t < 4; t++) begin
      case (t)
        0: set_tolerance('0);
        1: set_tolerance(TolMin);
        2: set_tolerance(TolTop);
        default: set_tolerance('1);
      endcase
      for (int k = 0; k < 4; k++) begin
        start = (k == 0) ? 0 : k + 1;
        send_interval(XW'(start) << FracBits, XW'(start + 1) << FracBits);
      end
    end
  endtask

  task automatic test_random_intervals(int unsigned send_pct, int unsigned recv_pct,
                                       int unsigned count);
    logic [XW-1:0] lo, hi, swap;
    logic signed [63:0] f_lo, f_hi;
    int unsigned pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int chunk = 0; chunk < 4; chunk++) begin
      case (chunk)
        0: set_tolerance(TolW'(1));
        1: set_tolerance(TolW'($urandom_range(64, 2)));
        2: set_tolerance(TolW'($urandom_range(1 << 20, 65)));
        default: set_tolerance(TolW'($urandom_range((1 << TolW) - 1, 0)));
      endcase
      for (int n = 0; n < count / 4; n++) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          // proper bracket: ordered ends with a strict sign change
          do begin
            lo = XW'($urandom_range(XFive));
            hi = XW'($urandom_range(XFive));
            if (lo > hi) begin
              swap = lo;
              lo = hi;
              hi = swap;
            end
            f_lo = spline_at(lo);
            f_hi = spline_at(hi);
          end while (f_lo == 0 || f_hi == 0 || f_lo[63] == f_hi[63]);
        end else if (pick < 85) begin
          lo = XW'($urandom());
          hi = XW'($urandom());
        end else if (pick < 95) begin
          lo = XW'($urandom_range(XFive));
          hi = XW'($urandom_range(XFive));
          if (hi > lo) begin
            swap = lo;
            lo = hi;
            hi = swap;
          end
        end else begin
          lo = XW'($urandom_range(XFive));
          hi = lo + XW'($urandom_range(3));
        end
        // now and then hold off until the pipeline is empty
        if ($urandom_range(49) == 0) wait_for_results();
        send_interval(lo, hi);
      end
    end
  endtask

  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.lower_bound = '0;
    in_if.upper_bound = '0;
    out_if.ready = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_reset();
    test_directed_intervals();
    test_tolerance_extremes();
    test_random_intervals(13, 49, 648);
    test_random_intervals(49, 13, 648);
    test_random_intervals(0, 0, 648);

    wait_for_results();
    repeat (DrainCycles) @(negedge clk_i);
    $display("%0d intervals sent, %0d results checked (%0d without sign change, %0d exact zeros)",
             intervals_sent, results_checked, no_sign_seen, exact_zero_seen);
    $display("%0d tolerance settings, %0d mismatches, %0d cycles",
             tol_settings, mismatch_count, cycle_count);
    if (mismatch_count == 0 && expected_roots.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/sbrf_pkg.sv
hdl/sbrf_if.sv
hdl/sbrf_horner.sv
hdl/spline_bisection_root_finder.sv
dv/testbench.sv
